### src/grc_pkg.sv
`default_nettype none

package grc_pkg;

    // Grid geometry and number formats.
    localparam int GRID_W      = 64;
    localparam int GRID_H      = 64;
    localparam int CELL_BITS   = 8;
    localparam int ANGLE_BITS  = 12;
    localparam int FRAC_BITS   = 16;
    localparam int COORD_BITS  = 6;
    localparam int POS_BITS    = 22;
    localparam int ADDR_BITS   = 12;
    localparam int GRID_DEPTH  = GRID_W * GRID_H;

    // Trig is Q1.15; the Taylor argument is Q1.30.
    localparam int TRIG_BITS   = 16;
    localparam int MAG_BITS    = 15;
    localparam int X_BITS      = 31;
    localparam int TERM_BITS   = 32;
    localparam int SUM_BITS    = 34;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam int TAYLOR_TERMS = 7;
    localparam int RECIP_BITS  = 33;

    // Iterative divider sizes.
    localparam int DIV_NUM_W   = 40;
    localparam int DIV_QUO_W   = 32;

    // Depth arithmetic.
    localparam int DEPTH_BITS  = 22;
    localparam int QACC_BITS   = 33;
    localparam logic [DEPTH_BITS-1:0] MAX_DEPTH_RESET = 22'd1310720;

    // Item kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;

    // Register index codes (paddr[2]).
    localparam logic REG_MAX_DEPTH = 1'b0;

    typedef struct packed {
        logic                  kind;
        logic [COORD_BITS-1:0] cell_x;
        logic [COORD_BITS-1:0] cell_y;
        logic [CELL_BITS-1:0]  cell_value;
        logic [POS_BITS-1:0]   pos_x;
        logic [POS_BITS-1:0]   pos_y;
        logic [ANGLE_BITS-1:0] angle;
    } in_item_t;

    typedef struct packed {
        logic                  hit;
        logic [DEPTH_BITS-1:0] depth;
        logic [COORD_BITS-1:0] hit_x;
        logic [COORD_BITS-1:0] hit_y;
        logic [CELL_BITS-1:0]  hit_value;
    } out_item_t;

    // Request and status between the sequencer and the divider.
    typedef struct packed {
        logic                  start;
        logic [DIV_NUM_W-1:0]  num;
        logic [MAG_BITS-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic                  ovf;
        logic [DIV_QUO_W-1:0]  quot;
        logic [MAG_BITS-1:0]   rem;
    } div_stat_t;

    // Reciprocal of the divisor (2k)(2k+1) of the k-th Taylor term, rounded up.
    // Multiplying a 32-bit term by it and shifting right gives the exact quotient.
    function automatic logic [RECIP_BITS-1:0] taylor_recip(input logic [2:0] k);
        logic [RECIP_BITS-1:0] m;
        begin
            case (k)
                3'd1:    m = 33'd5726623062;
                3'd2:    m = 33'd6871947674;
                3'd3:    m = 33'd6544712071;
                3'd4:    m = 33'd7635497416;
                3'd5:    m = 33'd4997780127;
                3'd6:    m = 33'd7048151461;
                3'd7:    m = 33'd5235769657;
                default: m = 33'd4294967296;
            endcase
            return m;
        end
    endfunction

    // Right shift that goes with each reciprocal.
    function automatic logic [5:0] taylor_shift(input logic [2:0] k);
        logic [5:0] s;
        begin
            case (k)
                3'd1:    s = 6'd35;
                3'd2:    s = 6'd37;
                3'd3:    s = 6'd38;
                3'd4:    s = 6'd39;
                3'd5:    s = 6'd39;
                3'd6:    s = 6'd40;
                3'd7:    s = 6'd40;
                default: s = 6'd32;
            endcase
            return s;
        end
    endfunction

endpackage

`default_nettype wire

### src/grc_ram.sv
`default_nettype none

module grc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/grc_div.sv
`default_nettype none

module grc_div import grc_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire div_req_t  req,
    output div_stat_t      stat
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 ovf_reg, ovf_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [MAG_BITS-1:0]  rem_reg, rem_next;
    logic [DIV_QUO_W-1:0] quo_reg, quo_next;
    logic [MAG_BITS-1:0]  den_reg, den_next;

    logic [MAG_BITS-1:0]  hi;
    logic [MAG_BITS:0]    trial;
    logic                 ge;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        hi        = MAG_BITS'(req.num[DIV_NUM_W-1:DIV_QUO_W]);
        trial     = {rem_reg, quo_reg[DIV_QUO_W-1]};
        ge        = (trial >= {1'b0, den_reg});

        if (req.start)
        begin
            den_next = req.den;
            quo_next = req.num[DIV_QUO_W-1:0];
            rem_next = hi;
            // The quotient does not fit when the high part reaches the divisor.
            if (hi >= req.den)
            begin
                ovf_next  = 1'b1;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                ovf_next  = 1'b0;
                done_next = 1'b0;
                busy_next = 1'b1;
                cnt_next  = 6'(DIV_QUO_W);
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? MAG_BITS'(trial - {1'b0, den_reg}) : MAG_BITS'(trial);
            quo_next = {quo_reg[DIV_QUO_W-2:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign stat.quot = quo_reg;
    assign stat.rem  = rem_reg;

endmodule

`default_nettype wire

### src/grid_ray_caster.sv
// Tile grid with a DDA ray caster. A write transaction stores one 8-bit cell
// of the 64 x 64 grid. A cast transaction computes the sine and cosine of the
// angle with a Taylor series (each of the seven terms takes two multiplies
// and a multiply by the reciprocal of its constant divisor), then walks the
// horizontal and the vertical grid-line crossings in turn: each axis needs
// two divisions and then steps cell by cell, one grid memory read per step.
// The result sits in an output register.
// After reset the grid is cleared by a pass over all 4096 cells, one cell per
// cycle, during which no transaction is accepted; the max_depth register is
// written over the APB port and should only change while no cast is in flight.

`default_nettype none

module grid_ray_caster import grc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire in_item_t    item,
    output logic             result_valid,
    input  wire logic        result_ready,
    output out_item_t        result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_TRIG_X,
        S_TRIG_M1,
        S_TRIG_M2,
        S_TRIG_DIV,
        S_TRIG_FIN,
        S_AX_INIT,
        S_AX_DIV0,
        S_AX_DIV1,
        S_AX_CHK,
        S_AX_MIN,
        S_AX_RD,
        S_AX_END,
        S_DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic [ADDR_BITS:0]           clr_cnt_reg, clr_cnt_next;
    in_item_t                     item_reg, item_next;
    logic [DEPTH_BITS-1:0]        max_depth_reg, max_depth_next;
    logic                         pass_reg, pass_next;
    logic                         sneg_reg, sneg_next;
    logic [X_BITS-1:0]            x_reg, x_next;
    logic [TERM_BITS-1:0]         term_reg, term_next;
    logic signed [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [2:0]                   k_reg, k_next;
    logic signed [TRIG_BITS-1:0]  sin_reg, sin_next;
    logic signed [TRIG_BITS-1:0]  cos_reg, cos_next;
    logic                         axis_reg, axis_next;
    logic                         fwd_reg, fwd_next;
    logic                         mpos_reg, mpos_next;
    logic [MAG_BITS-1:0]          mag_reg, mag_next;
    logic [MAG_BITS-1:0]          mmag_reg, mmag_next;
    logic signed [7:0]            idx_reg, idx_next;
    logic [QACC_BITS-1:0]         q_reg, q_next;
    logic [MAG_BITS-1:0]          r_reg, r_next;
    logic [DIV_QUO_W-1:0]         dq_reg, dq_next;
    logic [MAG_BITS-1:0]          dr_reg, dr_next;
    logic [POS_BITS-1:0]          off_reg, off_next;
    logic [POS_BITS-1:0]          pmin_reg, pmin_next;
    logic [COORD_BITS-1:0]        mc_reg, mc_next;
    out_item_t                    hres_reg, hres_next;
    out_item_t                    cur_reg, cur_next;
    out_item_t                    res_reg, res_next;
    logic                         res_valid_reg, res_valid_next;

    div_req_t                     div_req;
    div_stat_t                    div_stat;

    logic                         ram_we;
    logic [ADDR_BITS-1:0]         ram_addr;
    logic [CELL_BITS-1:0]         ram_wdata;
    logic [CELL_BITS-1:0]         ram_rdata;

    // Working values of the sequencer.
    logic [ANGLE_BITS-1:0]        ang;
    logic [ANGLE_BITS-3:0]        r_raw;
    logic [ANGLE_BITS-2:0]        r_fold;
    logic [42:0]                  x_prod;
    logic [62:0]                  t_prod;
    logic [64:0]                  d_prod;
    logic [DIV_QUO_W-1:0]         d_quot;
    logic [SUM_BITS-1:0]          s_pos;
    logic [SUM_BITS:0]            s_round;
    logic [19:0]                  s_q15;
    logic [TRIG_BITS-1:0]         trig_mag;
    logic signed [TRIG_BITS-1:0]  t_major, t_minor;
    logic [TRIG_BITS-1:0]         t_major_neg, t_minor_neg;
    logic [COORD_BITS-1:0]        start_cell;
    logic [POS_BITS-1:0]          p_major, p_minor;
    logic signed [24:0]           gap_raw;
    logic [22:0]                  gap;
    logic [36:0]                  off_prod;
    logic [23:0]                  m_val;
    logic                         m_neg;
    logic [7:0]                   mc_full;
    logic [MAG_BITS:0]            r_sum;
    logic                         r_carry;
    logic signed [7:0]            lim_major;
    logic [COORD_BITS-1:0]        hit_col, hit_row;
    logic                         take_h;
    logic                         item_acc;
    logic                         cfg_we;

    grc_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    grc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // APB register port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_MAX_DEPTH);
    assign prdata = (paddr[2] == REG_MAX_DEPTH) ? {10'd0, max_depth_reg} : 32'd0;

    assign item_ready   = (state_reg == S_IDLE);
    assign item_acc     = item_valid && item_ready;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Per-axis operand selection.
    assign t_major     = axis_reg ? cos_reg : sin_reg;
    assign t_minor     = axis_reg ? sin_reg : cos_reg;
    assign t_major_neg = TRIG_BITS'(-t_major);
    assign t_minor_neg = TRIG_BITS'(-t_minor);
    assign start_cell  = axis_reg ? item_reg.cell_x : item_reg.cell_y;
    assign p_major     = axis_reg ? item_reg.pos_x : item_reg.pos_y;
    assign p_minor     = axis_reg ? item_reg.pos_y : item_reg.pos_x;
    assign lim_major   = axis_reg ? 8'(GRID_W) : 8'(GRID_H);

    // Quadrant folding and the Taylor argument.
    assign ang    = pass_reg ? ANGLE_BITS'(item_reg.angle + ANGLE_BITS'(1 << (ANGLE_BITS - 2)))
                             : item_reg.angle;
    assign r_raw  = ang[ANGLE_BITS-3:0];
    assign r_fold = ang[ANGLE_BITS-2] ? (ANGLE_BITS-1)'((1 << (ANGLE_BITS - 2)) - r_raw)
                                      : {1'b0, r_raw};
    assign x_prod = 43'(r_fold) * 43'(PI_Q30);
    assign t_prod = 63'(term_reg) * 63'(x_reg);

    // Division of a term by its constant divisor through the reciprocal.
    assign d_prod = 65'(term_reg) * 65'(taylor_recip(k_reg));
    assign d_quot = DIV_QUO_W'(d_prod >> taylor_shift(k_reg));

    // Rounding of the series sum to Q15.
    assign s_pos   = sum_reg[SUM_BITS-1] ? '0 : sum_reg;
    assign s_round = {1'b0, s_pos} + (SUM_BITS+1)'(1 << 14);
    assign s_q15   = 20'(s_round >> 15);
    assign trig_mag = (s_q15 > 20'd32767) ? 16'd32767 : s_q15[TRIG_BITS-1:0];

    // Distance from the origin to the first grid line.
    assign gap_raw = (t_major > 0)
        ? $signed({2'b0, 7'(start_cell) + 7'd1, 16'd0}) - $signed({3'b0, p_major})
        : $signed({3'b0, p_major}) - $signed({3'b0, start_cell, 16'd0});
    assign gap     = gap_raw[24] ? 23'd0 : gap_raw[22:0];

    // Minor coordinate of the crossing.
    assign off_prod = 37'(q_reg[DEPTH_BITS-1:0]) * 37'(mmag_reg);
    assign m_neg    = !mpos_reg && (pmin_reg < off_reg);
    assign m_val    = mpos_reg ? ({2'b0, pmin_reg} + {2'b0, off_reg})
                               : ({2'b0, pmin_reg} - {2'b0, off_reg});
    assign mc_full  = m_val[23:16];

    // Incremental depth update: the numerator grows by 2^31 per crossing.
    assign r_sum   = {1'b0, r_reg} + {1'b0, dr_reg};
    assign r_carry = (r_sum >= {1'b0, mag_reg});

    assign hit_col = axis_reg ? COORD_BITS'(idx_reg) : mc_reg;
    assign hit_row = axis_reg ? mc_reg : COORD_BITS'(idx_reg);

    assign take_h = hres_reg.hit && (!cur_reg.hit || (hres_reg.depth <= cur_reg.depth));

    // Grid memory port.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = {hit_row, hit_col};
        ram_wdata = item.cell_value;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg[ADDR_BITS-1:0];
                ram_wdata = '0;
            end
            S_IDLE:
            begin
                ram_we   = item_acc && (item.kind == KIND_WRITE);
                ram_addr = {item.cell_y, item.cell_x};
            end
            S_AX_MIN:
            begin
                ram_addr = axis_reg ? {COORD_BITS'(mc_full), COORD_BITS'(idx_reg)}
                                    : {COORD_BITS'(idx_reg), COORD_BITS'(mc_full)};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        item_next      = item_reg;
        max_depth_next = cfg_we ? pwdata[DEPTH_BITS-1:0] : max_depth_reg;
        pass_next      = pass_reg;
        sneg_next      = sneg_reg;
        x_next         = x_reg;
        term_next      = term_reg;
        sum_next       = sum_reg;
        k_next         = k_reg;
        sin_next       = sin_reg;
        cos_next       = cos_reg;
        axis_next      = axis_reg;
        fwd_next       = fwd_reg;
        mpos_next      = mpos_reg;
        mag_next       = mag_reg;
        mmag_next      = mmag_reg;
        idx_next       = idx_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        dq_next        = dq_reg;
        dr_next        = dr_reg;
        off_next       = off_reg;
        pmin_next      = pmin_reg;
        mc_next        = mc_reg;
        hres_next      = hres_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        div_req.start  = 1'b0;
        div_req.num    = '0;
        div_req.den    = mag_reg;

        if (res_valid_reg && result_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (ADDR_BITS+1)'(GRID_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_acc && (item.kind == KIND_CAST))
                begin
                    item_next  = item;
                    pass_next  = 1'b0;
                    state_next = S_TRIG_X;
                end
            end
            S_TRIG_X:
            begin
                x_next     = x_prod[41:11];
                term_next  = {1'b0, x_prod[41:11]};
                sum_next   = $signed({3'b0, x_prod[41:11]});
                k_next     = 3'd1;
                sneg_next  = ang[ANGLE_BITS-1];
                state_next = S_TRIG_M1;
            end
            S_TRIG_M1:
            begin
                term_next  = t_prod[61:30];
                state_next = S_TRIG_M2;
            end
            S_TRIG_M2:
            begin
                term_next  = t_prod[61:30];
                state_next = S_TRIG_DIV;
            end
            S_TRIG_DIV:
            begin
                // The divided term is added or subtracted in the same cycle.
                term_next = d_quot;
                sum_next  = k_reg[0] ? (sum_reg - $signed({2'b0, d_quot}))
                                     : (sum_reg + $signed({2'b0, d_quot}));
                if (k_reg == 3'(TAYLOR_TERMS))
                begin
                    state_next = S_TRIG_FIN;
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = S_TRIG_M1;
                end
            end
            S_TRIG_FIN:
            begin
                if (pass_reg)
                begin
                    cos_next   = sneg_reg ? $signed(TRIG_BITS'(-trig_mag)) : $signed(trig_mag);
                    axis_next  = 1'b0;
                    state_next = S_AX_INIT;
                end
                else
                begin
                    sin_next   = sneg_reg ? $signed(TRIG_BITS'(-trig_mag)) : $signed(trig_mag);
                    pass_next  = 1'b1;
                    state_next = S_TRIG_X;
                end
            end
            S_AX_INIT:
            begin
                cur_next  = '0;
                fwd_next  = (t_major > 0);
                mag_next  = (t_major > 0) ? t_major[MAG_BITS-1:0] : t_major_neg[MAG_BITS-1:0];
                mpos_next = !t_minor[TRIG_BITS-1];
                mmag_next = t_minor[TRIG_BITS-1] ? t_minor_neg[MAG_BITS-1:0]
                                                 : t_minor[MAG_BITS-1:0];
                idx_next  = (t_major > 0) ? ($signed({2'b0, start_cell}) + 8'sd1)
                                          : ($signed({2'b0, start_cell}) - 8'sd1);
                pmin_next = p_minor;
                // An axis with zero trig never crosses a line.
                if (t_major == '0)
                begin
                    state_next = S_AX_END;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = {2'd0, gap, 15'd0};
                    div_req.den   = (t_major > 0) ? t_major[MAG_BITS-1:0]
                                                  : t_major_neg[MAG_BITS-1:0];
                    state_next    = S_AX_DIV0;
                end
            end
            S_AX_DIV0:
            begin
                if (div_stat.done)
                begin
                    if (div_stat.ovf)
                    begin
                        state_next = S_AX_END;
                    end
                    else
                    begin
                        q_next        = {1'b0, div_stat.quot};
                        r_next        = div_stat.rem;
                        div_req.start = 1'b1;
                        div_req.num   = DIV_NUM_W'(1) << 31;
                        div_req.den   = mag_reg;
                        state_next    = S_AX_DIV1;
                    end
                end
            end
            S_AX_DIV1:
            begin
                if (div_stat.done)
                begin
                    dq_next    = div_stat.quot;
                    dr_next    = div_stat.rem;
                    state_next = S_AX_CHK;
                end
            end
            S_AX_CHK:
            begin
                off_next = off_prod[36:15];
                if (q_reg >= {11'd0, max_depth_reg})
                begin
                    state_next = S_AX_END;
                end
                else if ((idx_reg < 0) || (idx_reg >= lim_major))
                begin
                    state_next = S_AX_END;
                end
                else
                begin
                    state_next = S_AX_MIN;
                end
            end
            S_AX_MIN:
            begin
                mc_next = COORD_BITS'(mc_full);
                if (m_neg || (mc_full >= (axis_reg ? 8'(GRID_H) : 8'(GRID_W))))
                begin
                    state_next = S_AX_END;
                end
                else
                begin
                    state_next = S_AX_RD;
                end
            end
            S_AX_RD:
            begin
                if (ram_rdata != '0)
                begin
                    cur_next.hit       = 1'b1;
                    cur_next.depth     = q_reg[DEPTH_BITS-1:0];
                    cur_next.hit_x     = hit_col;
                    cur_next.hit_y     = hit_row;
                    cur_next.hit_value = ram_rdata;
                    state_next         = S_AX_END;
                end
                else
                begin
                    idx_next   = fwd_reg ? (idx_reg + 8'sd1) : (idx_reg - 8'sd1);
                    q_next     = q_reg + {1'b0, dq_reg} + QACC_BITS'(r_carry);
                    r_next     = r_carry ? MAG_BITS'(r_sum - {1'b0, mag_reg})
                                         : MAG_BITS'(r_sum);
                    state_next = S_AX_CHK;
                end
            end
            S_AX_END:
            begin
                if (!axis_reg)
                begin
                    hres_next  = cur_reg;
                    axis_next  = 1'b1;
                    state_next = S_AX_INIT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_next       = take_h ? hres_reg : cur_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            max_depth_reg <= MAX_DEPTH_RESET;
            res_valid_reg <= 1'b0;
            pass_reg      <= 1'b0;
            axis_reg      <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            max_depth_reg <= max_depth_next;
            res_valid_reg <= res_valid_next;
            pass_reg      <= pass_next;
            axis_reg      <= axis_next;
            k_reg         <= k_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        sneg_reg <= sneg_next;
        x_reg    <= x_next;
        term_reg <= term_next;
        sum_reg  <= sum_next;
        sin_reg  <= sin_next;
        cos_reg  <= cos_next;
        fwd_reg  <= fwd_next;
        mpos_reg <= mpos_next;
        mag_reg  <= mag_next;
        mmag_reg <= mmag_next;
        idx_reg  <= idx_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        dq_reg   <= dq_next;
        dr_reg   <= dr_next;
        off_reg  <= off_next;
        pmin_reg <= pmin_next;
        mc_reg   <= mc_next;
        hres_reg <= hres_next;
        cur_reg  <= cur_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

### src/grc_checker.sv
`default_nettype none

module grc_assertions import grc_pkg::*; (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_valid,
    input wire logic        item_ready,
    input wire in_item_t    item,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire out_item_t   result,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    // A stalled result transaction holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // A miss carries an all-zero payload.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.hit |->
            result.depth == '0 && result.hit_x == '0 && result.hit_y == '0 &&
            result.hit_value == '0)
        else $error("miss with nonzero payload");

    // A hit always reports a non-empty cell.
    a_hit_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.hit |-> result.hit_value != '0)
        else $error("hit on an empty cell");

    // A grid write produces no result.
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.kind == KIND_WRITE |=> !$rose(result_valid))
        else $error("result after a write transaction");

    // A depth limit write reads back on the next cycle.
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr == 3'd0 |=>
            (paddr != 3'd0) || (prdata == {10'd0, $past(pwdata[DEPTH_BITS-1:0])}))
        else $error("depth limit does not read back");

endmodule

bind grid_ray_caster grc_assertions u_grc_assertions (.*);

`default_nettype wire
